[rtl/agc_pkg.sv]
package agc_pkg;

    localparam int DEF_FIR_TAPS   = 29;
    localparam int DEF_WINDOW_LEN = 20;
    localparam int DEF_COEF_WIDTH = 16;

    localparam int TAB_LEN   = 29;
    localparam int SAMPLE_W  = 16;
    localparam int FILT_W    = 24;
    localparam int GEST_W    = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZLEVEL  = 2'd2;

    localparam logic [CFG_W-1:0]        RST_MARGIN  = 16'd5;
    localparam logic [CFG_W-1:0]        RST_HOLDOFF = 16'd300;
    localparam logic signed [CFG_W-1:0] RST_ZLEVEL  = 16'sd200;

    localparam logic [GEST_W-1:0] GEST_NONE  = 3'd0;
    localparam logic [GEST_W-1:0] GEST_LEFT  = 3'd1;
    localparam logic [GEST_W-1:0] GEST_RIGHT = 3'd2;
    localparam logic [GEST_W-1:0] GEST_DOWN  = 3'd3;
    localparam logic [GEST_W-1:0] GEST_UP    = 3'd4;

    localparam logic signed [15:0] COEF_Q15 [TAB_LEN] = '{
        16'sd60,  16'sd67,  16'sd76,  16'sd88,  16'sd103, 16'sd120, 16'sd139, 16'sd159,
        16'sd181, 16'sd205, 16'sd228, 16'sd252, 16'sd276, 16'sd300, 16'sd322, 16'sd344,
        16'sd364, 16'sd381, 16'sd397, 16'sd409, 16'sd419, 16'sd426, 16'sd429, 16'sd429,
        16'sd425, 16'sd418, 16'sd407, 16'sd392, 16'sd375
    };

    typedef logic [2:0][SAMPLE_W-1:0] t_axes16;
    typedef logic [2:0][FILT_W-1:0]   t_axes24;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
    } t_in_item;

    typedef struct packed {
        logic [GEST_W-1:0] gesture;
        logic              window_full;
        logic [FILT_W-1:0] std_dev_x;
        logic [FILT_W-1:0] std_dev_y;
        logic [FILT_W-1:0] std_dev_z;
    } t_out_item;

    function automatic logic signed [23:0] coef_at(input int k, input int cw);
        int                 d;
        logic signed [31:0] c;
        logic signed [31:0] r;
        d = cw - 16;
        r = '0;
        if (k >= 0 && k < TAB_LEN) begin
            c = 32'(COEF_Q15[k]);
            if (d >= 0) begin
                r = c <<< d;
            end else begin
                r = (c + (32'sd1 <<< (-d - 1))) >>> (-d);
            end
        end
        return r[23:0];
    endfunction

    function automatic logic [FILT_W-1:0] abs_diff(input logic [FILT_W-1:0] a,
                                                   input logic [FILT_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

endpackage

[rtl/agc_stream_if.sv]
interface agc_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/agc_fir.sv]
module agc_fir #(
    parameter int FIR_TAPS   = agc_pkg::DEF_FIR_TAPS,
    parameter int COEF_WIDTH = agc_pkg::DEF_COEF_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  agc_pkg::t_axes16 i_sample,
    output logic             o_done,
    output agc_pkg::t_axes24 o_filt
);

    localparam int A_W   = (FIR_TAPS > 1) ? $clog2(FIR_TAPS) : 1;
    localparam int C_W   = $clog2(FIR_TAPS + 1);
    localparam int P_W   = agc_pkg::SAMPLE_W + COEF_WIDTH;
    localparam int ACC_W = P_W + C_W + 1;
    localparam int FSH   = COEF_WIDTH - 9;
    localparam int FSH_R = (FSH > 0) ? FSH : 0;
    localparam int FSH_L = (FSH < 0) ? -FSH : 0;
    localparam logic signed [ACC_W+1:0] HALF =
        (FSH_R > 0) ? (ACC_W+2)'(64'(1) << ((FSH_R > 0) ? FSH_R - 1 : 0)) : '0;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_RUN  = 4'b0010,
        F_WAIT = 4'b0100,
        F_FIN  = 4'b1000
    } t_fstate;

    t_fstate r_state;
    logic [3*agc_pkg::SAMPLE_W-1:0] r_dl [FIR_TAPS];

    logic [A_W-1:0] r_head, r_new, w_addr, w_ka;
    logic [C_W-1:0] r_cnt, r_k;
    logic           r_rv, r_rl, r_rok, r_pv, r_pl, r_done;
    logic [3*agc_pkg::SAMPLE_W-1:0] r_rd;
    logic signed [COEF_WIDTH-1:0]   r_coef;
    logic signed [P_W-1:0]          r_p   [3];
    logic signed [ACC_W-1:0]        r_acc [3];
    logic signed [ACC_W+1:0]        w_t   [3];
    agc_pkg::t_axes24               r_filt, w_rnd;

    assign w_ka   = r_k[A_W-1:0];
    assign w_addr = (r_new >= w_ka) ? r_new - w_ka : r_new + A_W'(FIR_TAPS) - w_ka;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dl[r_head] <= i_sample;
        end
        r_rd   <= r_dl[w_addr];
        r_coef <= COEF_WIDTH'(agc_pkg::coef_at(int'(r_k), COEF_WIDTH));
        r_rok  <= (r_k < r_cnt);
        for (int a = 0; a < 3; a++) begin
            if (r_rok) begin
                r_p[a] <= P_W'($signed(r_rd[a*agc_pkg::SAMPLE_W +: agc_pkg::SAMPLE_W]) * r_coef);
            end else begin
                r_p[a] <= '0;
            end
            if (i_start) begin
                r_acc[a] <= '0;
            end else if (r_pv) begin
                r_acc[a] <= r_acc[a] + ACC_W'(r_p[a]);
            end
        end
        if (r_state == F_FIN) begin
            r_filt <= w_rnd;
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (FSH_R > 0) begin
                w_t[a] = ((ACC_W+2)'(r_acc[a]) + HALF) >>> FSH_R;
            end else begin
                w_t[a] = (ACC_W+2)'(r_acc[a]) <<< FSH_L;
            end
            if (w_t[a][ACC_W+1:23] != {(ACC_W-21){w_t[a][ACC_W+1]}}) begin
                w_rnd[a] = w_t[a][ACC_W+1] ? 24'h800000 : 24'h7FFFFF;
            end else begin
                w_rnd[a] = w_t[a][23:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_head  <= '0;
            r_new   <= '0;
            r_cnt   <= '0;
            r_k     <= '0;
            r_rv    <= 1'b0;
            r_rl    <= 1'b0;
            r_pv    <= 1'b0;
            r_pl    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_rv   <= 1'b0;
            r_rl   <= 1'b0;
            r_pv   <= r_rv;
            r_pl   <= r_rv && r_rl;
            r_done <= 1'b0;
            unique case (r_state)
                F_IDLE: begin
                    if (i_start) begin
                        r_new   <= r_head;
                        r_head  <= (r_head == A_W'(FIR_TAPS - 1)) ? '0 : r_head + 1'b1;
                        r_cnt   <= (r_cnt == C_W'(FIR_TAPS)) ? r_cnt : r_cnt + 1'b1;
                        r_k     <= '0;
                        r_state <= F_RUN;
                    end
                end
                F_RUN: begin
                    r_rv <= 1'b1;
                    r_rl <= (r_k == C_W'(FIR_TAPS - 1));
                    r_k  <= r_k + 1'b1;
                    if (r_k == C_W'(FIR_TAPS - 1)) begin
                        r_state <= F_WAIT;
                    end
                end
                F_WAIT: begin
                    if (r_pl) begin
                        r_state <= F_FIN;
                    end
                end
                F_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_filt = r_filt;

endmodule

[rtl/agc_stat.sv]
module agc_stat #(
    parameter int WINDOW_LEN = agc_pkg::DEF_WINDOW_LEN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [$clog2(WINDOW_LEN)-1:0] i_waddr,
    input  agc_pkg::t_axes24              i_wdata,
    input  logic                          i_start,
    output logic                          o_done,
    output agc_pkg::t_axes24              o_sd
);

    localparam int WP_W   = $clog2(WINDOW_LEN);
    localparam int I_W    = $clog2(WINDOW_LEN + 1);
    localparam int S_W    = 24 + I_W;
    localparam int SQ_W   = 47 + I_W;
    localparam int DIFF_W = SQ_W + I_W;
    localparam int ROOT_W = (DIFF_W + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int CNT_W  = $clog2(ROOT_W + 1);
    localparam int RCP_SH = ROOT_W + $clog2(WINDOW_LEN);
    localparam int RCP_W  = ROOT_W + 1;
    localparam int PROD_W = ROOT_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP =
        RCP_W'((64'd1 << RCP_SH) / 64'(WINDOW_LEN) + 64'd1);

    typedef enum logic [7:0] {
        T_IDLE = 8'b0000_0001,
        T_READ = 8'b0000_0010,
        T_WAIT = 8'b0000_0100,
        T_MUL  = 8'b0000_1000,
        T_SUB  = 8'b0001_0000,
        T_LOAD = 8'b0010_0000,
        T_DIV  = 8'b0100_0000,
        T_SQRT = 8'b1000_0000
    } t_tstate;

    t_tstate r_state;
    logic [3*agc_pkg::FILT_W-1:0] r_win [WINDOW_LEN];
    logic [3*agc_pkg::FILT_W-1:0] r_rd;

    logic [I_W-1:0]          r_i;
    logic                    r_rv, r_rl, r_qv, r_ql, r_done;
    logic signed [23:0]      r_val  [3];
    logic [47:0]             r_sqr  [3];
    logic signed [S_W-1:0]   r_sum  [3];
    logic [SQ_W-1:0]         r_ssq  [3];
    logic [DIFF_W-1:0]       r_nsq  [3];
    logic [DIFF_W-1:0]       r_s2   [3];
    logic [DIFF_W-1:0]       r_diff [3];
    logic [S_W-1:0]          w_abs  [3];
    logic [2*S_W-1:0]        w_sq2  [3];
    logic [DIFF_W-1:0]       w_nsq  [3];
    logic [1:0]              r_ax;
    logic [RAD_W-1:0]        r_rad;
    logic [ROOT_W-1:0]       r_root, w_root_n;
    logic [ROOT_W+1:0]       r_srem, w_srem_n;
    logic [ROOT_W+3:0]       w_st, w_trial;
    logic                    w_sge;
    logic [PROD_W-1:0]       r_prod;
    logic [ROOT_W-1:0]       w_quo;
    logic [CNT_W-1:0]        r_cnt;
    agc_pkg::t_axes24        r_sd;
    logic [23:0]             w_clamp;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_abs[a] = (r_sum[a] < 0) ? S_W'(-r_sum[a]) : S_W'(r_sum[a]);
            w_sq2[a] = w_abs[a] * w_abs[a];
            w_nsq[a] = r_ssq[a] * DIFF_W'(WINDOW_LEN);
        end
        w_st     = {r_srem, r_rad[RAD_W-1 -: 2]};
        w_trial  = (ROOT_W+4)'({r_root, 2'b01});
        w_sge    = (w_st >= w_trial);
        w_srem_n = w_sge ? (ROOT_W+2)'(w_st - w_trial) : (ROOT_W+2)'(w_st);
        w_root_n = {r_root[ROOT_W-2:0], w_sge};
        w_quo    = ROOT_W'(r_prod >> RCP_SH);
        w_clamp  = (|w_quo[ROOT_W-1:24]) ? 24'hFFFFFF : w_quo[23:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_win[i_waddr] <= i_wdata;
        end
        r_rd <= r_win[r_i[WP_W-1:0]];
        for (int a = 0; a < 3; a++) begin
            r_val[a] <= $signed(r_rd[a*24 +: 24]);
            r_sqr[a] <= 48'($signed(r_rd[a*24 +: 24]) * $signed(r_rd[a*24 +: 24]));
            if (i_start) begin
                r_sum[a] <= '0;
                r_ssq[a] <= '0;
            end else if (r_qv) begin
                r_sum[a] <= r_sum[a] + S_W'(r_val[a]);
                r_ssq[a] <= r_ssq[a] + SQ_W'(r_sqr[a]);
            end
            if (r_state == T_MUL) begin
                r_nsq[a] <= w_nsq[a];
                r_s2[a]  <= DIFF_W'(w_sq2[a]);
            end
            if (r_state == T_SUB) begin
                r_diff[a] <= r_nsq[a] - r_s2[a];
            end
        end
        case (r_state)
            T_LOAD: begin
                r_rad  <= RAD_W'(r_diff[r_ax]);
                r_root <= '0;
                r_srem <= '0;
            end
            T_SQRT: begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_root <= w_root_n;
                r_srem <= w_srem_n;
            end
            T_DIV: begin
                if (r_cnt == '0) begin
                    r_prod <= r_root * RCP;
                end else begin
                    r_sd[r_ax] <= w_clamp;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_i     <= '0;
            r_rv    <= 1'b0;
            r_rl    <= 1'b0;
            r_qv    <= 1'b0;
            r_ql    <= 1'b0;
            r_ax    <= '0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_rv   <= 1'b0;
            r_rl   <= 1'b0;
            r_qv   <= r_rv;
            r_ql   <= r_rv && r_rl;
            r_done <= 1'b0;
            unique case (r_state)
                T_IDLE: begin
                    if (i_start) begin
                        r_i     <= '0;
                        r_state <= T_READ;
                    end
                end
                T_READ: begin
                    r_rv <= 1'b1;
                    r_rl <= (r_i == I_W'(WINDOW_LEN - 1));
                    r_i  <= r_i + 1'b1;
                    if (r_i == I_W'(WINDOW_LEN - 1)) begin
                        r_state <= T_WAIT;
                    end
                end
                T_WAIT: begin
                    if (r_ql) begin
                        r_state <= T_MUL;
                    end
                end
                T_MUL: r_state <= T_SUB;
                T_SUB: begin
                    r_ax    <= '0;
                    r_state <= T_LOAD;
                end
                T_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= T_SQRT;
                end
                T_SQRT: begin
                    if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                        r_cnt   <= '0;
                        r_state <= T_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                T_DIV: begin
                    if (r_cnt == CNT_W'(1)) begin
                        r_cnt <= '0;
                        if (r_ax == 2'd2) begin
                            r_done  <= 1'b1;
                            r_state <= T_IDLE;
                        end else begin
                            r_ax    <= r_ax + 1'b1;
                            r_state <= T_LOAD;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sd   = r_sd;

endmodule

[rtl/accel_gesture_classifier.sv]
// Each accepted sample passes through the FIR filter; once the window is full, the window
// statistics follow, with a serial square root of ROOT_W bits per axis, ROOT_W being half
// the variance numerator width rounded up; the serial square roots take most of the time.
// Samples are taken one at a time: the next is accepted in the cycle after the result is
// loaded into the output register.
// Reset clears the delay-line fill, window pointer, fill and holdoff counts, and
// loads the register defaults; the window memory is not cleared.
module accel_gesture_classifier #(
    parameter int FIR_TAPS   = agc_pkg::DEF_FIR_TAPS,
    parameter int WINDOW_LEN = agc_pkg::DEF_WINDOW_LEN,
    parameter int COEF_WIDTH = agc_pkg::DEF_COEF_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    agc_stream_if.sink                        i_sample,
    agc_stream_if.source                      o_result,
    input  logic                              i_cfg_we,
    input  logic [agc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [agc_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int WP_W = $clog2(WINDOW_LEN);
    localparam int FC_W = $clog2(WINDOW_LEN + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FIR  = 4'b0010,
        S_STAT = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [15:0]          r_margin, r_holdoff;
    logic signed [15:0]   r_zlevel;
    logic [WP_W-1:0]      r_wptr, n_wptr;
    logic [FC_W-1:0]      r_fill, n_fill, w_fill_inc;
    logic [15:0]          r_hold, n_hold;
    logic signed [23:0]   r_fx, r_fz;
    agc_pkg::t_out_item   r_res, n_res, r_out;
    logic                 r_out_valid, n_out_valid;
    logic                 w_in_fire, w_out_fire, w_fir_done, w_stat_start, w_stat_done;
    logic                 w_win_wr, w_full, w_report, w_load, w_still, w_xd, w_zd;
    agc_pkg::t_in_item    w_in;
    agc_pkg::t_axes16     w_samp;
    agc_pkg::t_axes24     w_filt, w_sd;
    logic [23:0]          w_m;
    logic [2:0]           w_gest;

    assign w_in       = i_sample.payload;
    assign w_samp     = {w_in.accel_z, w_in.accel_y, w_in.accel_x};
    assign w_in_fire  = i_sample.valid && i_sample.ready;
    assign w_out_fire = r_out_valid && o_result.ready;
    assign i_sample.ready = (r_state == S_IDLE);
    assign w_win_wr   = (r_state == S_FIR) && w_fir_done;

    agc_fir #(
        .FIR_TAPS   (FIR_TAPS),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_fir (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_in_fire),
        .i_sample (w_samp),
        .o_done   (w_fir_done),
        .o_filt   (w_filt)
    );

    agc_stat #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_stat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_win_wr),
        .i_waddr (r_wptr),
        .i_wdata (w_filt),
        .i_start (w_stat_start),
        .o_done  (w_stat_done),
        .o_sd    (w_sd)
    );

    assign w_fill_inc = (r_fill == FC_W'(WINDOW_LEN)) ? r_fill : r_fill + 1'b1;
    assign w_full     = (w_fill_inc == FC_W'(WINDOW_LEN));
    assign w_m        = {r_margin, 8'h00};
    assign w_still    = (agc_pkg::abs_diff(w_sd[0], w_sd[1]) < w_m) &&
                        (agc_pkg::abs_diff(w_sd[1], w_sd[2]) < w_m) &&
                        (agc_pkg::abs_diff(w_sd[2], w_sd[0]) < w_m);
    assign w_xd       = (w_sd[0] > w_sd[1]) && (w_sd[0] > w_sd[2]);
    assign w_zd       = (w_sd[2] > w_sd[0]) && (w_sd[2] > w_sd[1]);
    assign w_report   = !w_still && (w_xd || w_zd) && (r_hold >= r_holdoff);
    assign w_gest     = w_xd ? ((r_fx < 0) ? agc_pkg::GEST_LEFT : agc_pkg::GEST_RIGHT)
                             : ((r_fz < $signed({r_zlevel, 8'h00})) ? agc_pkg::GEST_DOWN
                                                                   : agc_pkg::GEST_UP);

    always_comb begin
        n_state      = r_state;
        n_wptr       = r_wptr;
        n_fill       = r_fill;
        n_hold       = r_hold;
        n_res        = r_res;
        w_stat_start = 1'b0;
        w_load       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = S_FIR;
                end
            end
            S_FIR: begin
                if (w_fir_done) begin
                    n_wptr = (r_wptr == WP_W'(WINDOW_LEN - 1)) ? '0 : r_wptr + 1'b1;
                    n_fill = w_fill_inc;
                    n_hold = (&r_hold) ? r_hold : r_hold + 1'b1;
                    if (w_full) begin
                        w_stat_start = 1'b1;
                        n_state      = S_STAT;
                    end else begin
                        n_res.gesture     = agc_pkg::GEST_NONE;
                        n_res.window_full = 1'b0;
                        n_res.std_dev_x   = '0;
                        n_res.std_dev_y   = '0;
                        n_res.std_dev_z   = '0;
                        n_state           = S_DONE;
                    end
                end
            end
            S_STAT: begin
                if (w_stat_done) begin
                    n_res.gesture     = w_report ? w_gest : agc_pkg::GEST_NONE;
                    n_res.window_full = 1'b1;
                    n_res.std_dev_x   = w_sd[0];
                    n_res.std_dev_y   = w_sd[1];
                    n_res.std_dev_z   = w_sd[2];
                    if (w_report) begin
                        n_hold = '0;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = w_load ? 1'b1 : (w_out_fire ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wptr      <= '0;
            r_fill      <= '0;
            r_hold      <= '0;
            r_out_valid <= 1'b0;
            r_margin    <= agc_pkg::RST_MARGIN;
            r_holdoff   <= agc_pkg::RST_HOLDOFF;
            r_zlevel    <= agc_pkg::RST_ZLEVEL;
        end else begin
            r_state     <= n_state;
            r_wptr      <= n_wptr;
            r_fill      <= n_fill;
            r_hold      <= n_hold;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    agc_pkg::CFG_MARGIN:  r_margin  <= i_cfg_data;
                    agc_pkg::CFG_HOLDOFF: r_holdoff <= i_cfg_data;
                    agc_pkg::CFG_ZLEVEL:  r_zlevel  <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (w_win_wr) begin
            r_fx <= $signed(w_filt[0]);
            r_fz <= $signed(w_filt[2]);
        end
        if (w_load) begin
            r_out <= r_res;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    a_gest_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.gesture == agc_pkg::GEST_NONE || r_out.window_full))
        else $error("gesture reported before window full");

    a_hold_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STAT && w_stat_done && w_report) |=> (r_hold == '0))
        else $error("holdoff count not restarted after gesture");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FC_W'(WINDOW_LEN))
        else $error("fill count beyond window length");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == S_FIR && !i_sample.ready))
        else $error("sample taken while another is in progress");

endmodule

[test/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import agc_pkg::*;

    localparam int TAPS       = DEF_FIR_TAPS;
    localparam int WIN        = DEF_WINDOW_LEN;
    localparam int RUN_LIMIT  = 2_500_000;
    localparam int LONG_STALL = 4000;

    class gesture_scoreboard;
        logic [15:0]        margin;
        logic [15:0]        holdoff;
        logic signed [15:0] z_level;
        int                 taps [3][TAPS];
        int                 window [3][WIN];
        int                 wr_ptr;
        int                 fill;
        int                 since_gesture;
        t_out_item          pending [$];
        int                 mismatches;
        int                 gestures;
        int                 matched;

        function void clear();
            margin        = RST_MARGIN;
            holdoff       = RST_HOLDOFF;
            z_level       = RST_ZLEVEL;
            wr_ptr        = 0;
            fill          = 0;
            since_gesture = 0;
            foreach (taps[a, k]) taps[a][k] = 0;
            foreach (window[a, k]) window[a][k] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_MARGIN:  margin  = data;
                CFG_HOLDOFF: holdoff = data;
                CFG_ZLEVEL:  z_level = data;
                default: ;
            endcase
        endfunction

        function int filter_axis(int a, logic signed [15:0] smp);
            longint acc;
            acc = 0;
            for (int k = TAPS - 1; k > 0; k--) taps[a][k] = taps[a][k-1];
            taps[a][0] = smp;
            for (int k = 0; k < TAPS; k++) acc += longint'(COEF_Q15[k]) * taps[a][k];
            acc = (acc + 64) >>> 7;
            if (acc > 8388607) acc = 8388607;
            if (acc < -8388608) acc = -8388608;
            return int'(acc);
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function logic [23:0] deviation(int a);
            longint          s, v;
            longint unsigned sq, as, r;
            s  = 0;
            sq = 0;
            for (int i = 0; i < WIN; i++) begin
                v = window[a][i];
                s += v;
                sq += v * v;
            end
            as = (s < 0) ? -s : s;
            r  = int_sqrt((WIN * sq - as * as) / (WIN * WIN));
            return (r > 24'hFFFFFF) ? 24'hFFFFFF : r[23:0];
        endfunction

        function void note_sample(t_in_item smp);
            int          f [3];
            logic [23:0] sd [3];
            t_out_item   exp_item;
            logic [31:0] lim;
            bit          xd, zd;
            f[0] = filter_axis(0, smp.accel_x);
            f[1] = filter_axis(1, smp.accel_y);
            f[2] = filter_axis(2, smp.accel_z);
            for (int a = 0; a < 3; a++) window[a][wr_ptr] = f[a];
            wr_ptr = (wr_ptr + 1) % WIN;
            if (fill < WIN) fill++;
            if (since_gesture < 65535) since_gesture++;
            exp_item = '0;
            exp_item.gesture = GEST_NONE;
            if (fill >= WIN) begin
                exp_item.window_full = 1'b1;
                for (int a = 0; a < 3; a++) sd[a] = deviation(a);
                lim = {16'd0, margin} << 8;
                if (!(abs_diff(sd[0], sd[1]) < lim && abs_diff(sd[1], sd[2]) < lim &&
                      abs_diff(sd[2], sd[0]) < lim)) begin
                    xd = sd[0] > sd[1] && sd[0] > sd[2];
                    zd = sd[2] > sd[0] && sd[2] > sd[1];
                    if ((xd || zd) && since_gesture >= holdoff) begin
                        if (xd)
                            exp_item.gesture = (f[0] < 0) ? GEST_LEFT : GEST_RIGHT;
                        else
                            exp_item.gesture = (f[2] < int'(z_level) * 256) ? GEST_DOWN : GEST_UP;
                        since_gesture = 0;
                        gestures++;
                    end
                end
                exp_item.std_dev_x = sd[0];
                exp_item.std_dev_y = sd[1];
                exp_item.std_dev_z = sd[2];
            end
            pending.push_back(exp_item);
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                $error("unexpected result transaction %h", got);
                mismatches++;
                return;
            end
            e = pending.pop_front();
            matched++;
            if (got.gesture !== e.gesture) begin
                $error("gesture: expected %0d, got %0d", e.gesture, got.gesture);
                mismatches++;
            end
            if (got.window_full !== e.window_full) begin
                $error("window_full: expected %0d, got %0d", e.window_full, got.window_full);
                mismatches++;
            end
            if (got.std_dev_x !== e.std_dev_x) begin
                $error("std_dev_x: expected %0d, got %0d", e.std_dev_x, got.std_dev_x);
                mismatches++;
            end
            if (got.std_dev_y !== e.std_dev_y) begin
                $error("std_dev_y: expected %0d, got %0d", e.std_dev_y, got.std_dev_y);
                mismatches++;
            end
            if (got.std_dev_z !== e.std_dev_z) begin
                $error("std_dev_z: expected %0d, got %0d", e.std_dev_z, got.std_dev_z);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_MARGIN;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    agc_stream_if #(.t_payload(t_in_item))  smp_if ();
    agc_stream_if #(.t_payload(t_out_item)) res_if ();

    accel_gesture_classifier DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp_if.sink),
        .o_result   (res_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    gesture_scoreboard sb = new();
    int                cycles;
    int                settings_run;
    bit                stall_done;
    bit                rx_busy_idle;

    initial begin
        smp_if.valid   = 1'b0;
        smp_if.payload = '0;
        res_if.ready   = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(logic [15:0] margin, logic [15:0] holdoff, logic [15:0] zlev);
        smp_if.valid <= 1'b0;
        wait (sb.pending.size() == 0);
        repeat (4) @(posedge i_clk);
        write_reg(CFG_MARGIN, margin);
        write_reg(CFG_HOLDOFF, holdoff);
        write_reg(CFG_ZLEVEL, zlev);
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    task automatic send_sample(t_in_item smp, int gap);
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid   <= 1'b1;
        smp_if.payload <= smp;
        do @(posedge i_clk); while (!smp_if.ready);
        sb.note_sample(smp);
    endtask

    function automatic logic [15:0] around(int centre, int span);
        return 16'(centre + $signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic send_phase(int count, bit busy);
        t_in_item smp;
        int       mode, gap, zc;
        mode = 0;
        zc   = 0;
        for (int i = 0; i < count; i++) begin
            if (i % 25 == 0) begin
                mode = $urandom_range(0, 9);
                zc   = $signed($urandom_range(0, 60000)) - 30000;
            end
            case (mode)
                0, 1, 2: smp = '{16'($urandom), around(0, 150), around(0, 150)};
                3, 4, 5: smp = '{around(0, 150), around(0, 150), around(zc, 2000 + zc / 20)};
                6:       smp = '{around(0, 150), 16'($urandom), around(0, 150)};
                7:       smp = '{16'($urandom), 16'($urandom), 16'($urandom)};
                8:       smp = '{around(0, 20), around(0, 20), around(zc, 20)};
                default: smp = '{($urandom % 2) ? 16'h7FFF : 16'h8000,
                                 ($urandom % 2) ? 16'h7FFF : 16'h8000,
                                 ($urandom % 2) ? 16'h7FFF : 16'h8000};
            endcase
            gap = busy ? 0 : (($urandom % 4 == 0) ? 0 : $urandom_range(0, 14));
            send_sample(smp, gap);
        end
    endtask

    always begin
        int delay;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!stall_done && sb.matched == 300) begin
                stall_done = 1'b1;
                res_if.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
            end
            delay = rx_busy_idle ? 0 : $urandom_range(0, 14);
            if (delay > 0) begin
                res_if.ready <= 1'b0;
                repeat (delay) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            sb.check_result(res_if.payload);
            if (sb.matched % 64 == 0) rx_busy_idle = ($urandom % 3 == 0);
        end
    end

    initial begin
        t_in_item smp;
        sb.clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_sample('{16'h7FFF, 16'h7FFF, 16'h7FFF}, 0);
        send_sample('{16'h8000, 16'h8000, 16'h8000}, 0);
        send_sample('{16'h0000, 16'hFFFF, 16'h0001}, 3);
        send_sample('{16'h8000, 16'h7FFF, 16'h0000}, 0);
        for (int i = 0; i < 21; i++) begin
            smp = '{(i % 2) ? 16'h7FFF : 16'h8000, 16'hFFFF, (i < 10) ? 16'h8000 : 16'h0C80};
            send_sample(smp, i % 3);
        end

        configure(16'd0, 16'd0, 16'd0);
        send_phase(160, 1'b0);
        configure(16'd5, 16'd3, 16'sd200);
        send_phase(160, 1'b1);
        configure(16'hFFFF, 16'd0, 16'h8000);
        send_phase(110, 1'b0);
        configure(16'd1, 16'hFFFF, 16'h7FFF);
        send_phase(110, 1'b0);
        configure(16'd2, 16'd1, 16'h8000);
        send_phase(160, 1'b0);
        configure(16'd0, 16'd10, 16'h7FFF);
        send_phase(110, 1'b1);
        configure(16'($urandom_range(0, 40)), 16'($urandom_range(0, 30)), 16'($urandom));
        send_phase(215, 1'b0);
        smp_if.valid <= 1'b0;

        wait (sb.pending.size() == 0);
        repeat (400) @(posedge i_clk);
        $display("Run covered %0d samples and %0d results, %0d of them gestures,",
                 sb.matched, sb.matched, sb.gestures);
        $display("over %0d register settings beyond reset, with one long output stall.",
                 settings_run);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
